/* hw/rtl/avm_pkg.sv */
// Shared types and constants of the averaging voltmeter display unit.
// Request/response words, queue word, csr indexes and the segment table.
// No dependencies.
package avm_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd1;

   localparam logic [9:0] TRIGGER_PERIOD_RESET = 10'd20;
   localparam logic [6:0] FULL_SCALE_RESET = 7'd33;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef struct packed {
      logic       op;
      logic [9:0] sample;
   } req_type;

   typedef struct packed {
      logic [6:0] segments;
      logic       low_digit_on;
      logic       high_digit_on;
      logic       start_conversion;
      logic [7:0] shown_value;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic       last;
      logic [9:0] sample;
   } qword_type;

   typedef struct packed {
      logic       busy;
      logic       wr;
      logic [7:0] bcd;
   } scale_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'h0: pat = 7'h3F;
         4'h1: pat = 7'h06;
         4'h2: pat = 7'h5B;
         4'h3: pat = 7'h4F;
         4'h4: pat = 7'h66;
         4'h5: pat = 7'h6D;
         4'h6: pat = 7'h7D;
         4'h7: pat = 7'h07;
         4'h8: pat = 7'h7F;
         4'h9: pat = 7'h6F;
         4'hA: pat = 7'h77;
         4'hB: pat = 7'h7C;
         4'hC: pat = 7'h39;
         4'hD: pat = 7'h5E;
         4'hE: pat = 7'h79;
         default: pat = 7'h71;
      endcase
      return pat;
   endfunction

endpackage

/* hw/rtl/adc_average_voltmeter_display_unit.sv */
// Averaging voltmeter with multiplexed two-digit seven-segment output.
// A tick word is registered in the queue, then in the response register once that is free.
// One word per cycle while the queue has room; a tick right after a burst-closing
// sample waits queued until the conversion pipeline updates the shown value.
// Reset (synchronous): counters, sums and digits clear, registers reload.
// Depends on avm_pkg, avm_front, avm_fifo, avm_back.
module adc_average_voltmeter_display_unit #(
   parameter int SAMPLES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  avm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output avm_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [avm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [avm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import avm_pkg::*;

   logic      q_push, q_ready, q_pop, q_valid;
   qword_type q_in_word, q_out_word;

   avm_front #(.SAMPLES(SAMPLES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_word    (q_in_word)
   );

   avm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_ready),
      .push_word  (q_in_word),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_word   (q_out_word)
   );

   avm_back #(.SAMPLES(SAMPLES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (q_out_word),
      .q_pop     (q_pop),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/avm_front.sv */
// Front end: accepts request words, tags each as sample or tick and marks
// the sample that closes a burst. Depends on avm_pkg.
module avm_front #(
   parameter int SAMPLES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  avm_pkg::req_type   req_data,
   input  logic               q_ready,
   output logic               q_push,
   output avm_pkg::qword_type q_word
);
   import avm_pkg::*;

   localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   logic             is_sample;

   assign req_ready = q_ready;
   assign q_push = req_valid && q_ready;
   assign is_sample = (req_data.op == KIND_SAMPLE);
   assign last = (count_ff == CNT_W'(SAMPLES - 1));

   assign q_word.kind = is_sample ? KIND_SAMPLE : KIND_TICK;
   assign q_word.last = last;
   assign q_word.sample = req_data.sample;

   always_comb begin
      count_in = count_ff;
      if (q_push && is_sample) begin
         count_in = last ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/avm_fifo.sv */
// Short queue between front and back end.
// Depends on avm_pkg.
module avm_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               push_ready,
   input  avm_pkg::qword_type push_word,
   input  logic               pop,
   output logic               pop_valid,
   output avm_pkg::qword_type pop_word
);
   import avm_pkg::*;

   qword_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word = mem_ff[rd_ptr_ff];
   assign do_push = push && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/avm_scale.sv */
// Conversion pipeline: average, scale to tenths of a volt, round-divide by
// 1023, saturate and split into BCD digits. Depends on avm_pkg.
module avm_scale #(
   parameter int SAMPLES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(1023*SAMPLES+1)-1:0]    sum,
   input  logic [6:0]                           full_scale,
   output avm_pkg::scale_type                   st
);
   import avm_pkg::*;

   localparam int SUM_W = $clog2(1023 * SAMPLES + 1);
   localparam int L_W = $clog2(SAMPLES);
   localparam int SH = SUM_W + L_W;
   localparam int RECIP = (2 ** SH + SAMPLES - 1) / SAMPLES;
   localparam int REC_W = SH + 1;
   localparam int PROD_W = SUM_W + REC_W;

   logic             a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic [SUM_W-1:0] a_sum_ff;
   logic [9:0]       b_avg_ff;
   logic [17:0]      c_x_ff;
   logic [6:0]       d_q_ff;

   logic [PROD_W-1:0] avg_prod;
   logic [9:0]        avg_in;
   logic [17:0]       x_in;
   logic [27:0]       xm;
   logic [7:0]        q0;
   logic [18:0]       rem;
   logic [7:0]        qc;
   logic [6:0]        q_in;
   logic [14:0]       tens_prod;
   logic [3:0]        tens;
   logic [6:0]        ones_w;

   assign avg_prod = {{REC_W{1'b0}}, a_sum_ff} * {{SUM_W{1'b0}}, REC_W'(RECIP)};
   assign avg_in = avg_prod[SH +: 10];

   assign x_in = ({8'd0, b_avg_ff} * {11'd0, full_scale}) + 18'd511;

   assign xm = {10'd0, c_x_ff} + {c_x_ff, 10'd0};
   assign q0 = xm[27:20];
   assign rem = {1'b0, c_x_ff} + {11'd0, q0} - {1'b0, q0, 10'd0};
   assign qc = (rem >= 19'd1023) ? q0 + 8'd1 : q0;
   assign q_in = (qc > 8'd99) ? 7'd99 : qc[6:0];

   assign tens_prod = {8'd0, d_q_ff} * 15'd205;
   assign tens = tens_prod[14:11];
   assign ones_w = d_q_ff - (7'({tens, 3'b000}) + 7'({tens, 1'b0}));

   assign st.busy = a_v_ff || b_v_ff || c_v_ff || d_v_ff;
   assign st.wr = d_v_ff;
   assign st.bcd = {tens, ones_w[3:0]};

   always_ff @(posedge clock) begin
      a_sum_ff <= sum;
      b_avg_ff <= avg_in;
      c_x_ff <= x_in;
      d_q_ff <= q_in;
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

endmodule

/* hw/rtl/avm_back.sv */
// Back end: accumulates samples, runs conversions, counts ticks and drives
// the display word into the response register. Depends on avm_pkg, avm_scale.
module avm_back #(
   parameter int SAMPLES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  avm_pkg::qword_type                   q_word,
   output logic                                 q_pop,
   input  logic                                 csr_wr_en,
   input  logic [avm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [avm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output avm_pkg::rsp_type                     rsp_data
);
   import avm_pkg::*;

   localparam int SUM_W = $clog2(1023 * SAMPLES + 1);

   logic [9:0]       period_ff;
   logic [6:0]       full_scale_ff;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [7:0]       bcd_ff;
   logic             show_high_ff;
   logic [9:0]       tick_ff, tick_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_free, is_tick, pop_sample, pop_tick, start;
   logic [10:0]      tick_next;
   logic [3:0]       digit;
   scale_type        st;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_tick = (q_word.kind == KIND_TICK);
   assign q_pop = q_valid && (!is_tick || (out_free && !st.busy));
   assign pop_sample = q_pop && !is_tick;
   assign pop_tick = q_pop && is_tick;

   assign sum_add = sum_ff + SUM_W'(q_word.sample);
   assign start = pop_sample && q_word.last;

   always_comb begin
      sum_in = sum_ff;
      if (pop_sample) begin
         sum_in = q_word.last ? '0 : sum_add;
      end
   end

   avm_scale #(.SAMPLES(SAMPLES)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sum        (sum_add),
      .full_scale (full_scale_ff),
      .st         (st)
   );

   assign tick_next = {1'b0, tick_ff} + 11'd1;
   assign tick_in = (tick_next >= {1'b0, period_ff}) ? '0 : tick_next[9:0];
   assign digit = show_high_ff ? bcd_ff[7:4] : bcd_ff[3:0];

   always_comb begin
      rsp_data_in.segments = seg_pattern(digit);
      rsp_data_in.low_digit_on = !show_high_ff;
      rsp_data_in.high_digit_on = show_high_ff;
      rsp_data_in.start_conversion = (tick_ff == '0);
      rsp_data_in.shown_value = bcd_ff;
      if (pop_tick) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (pop_tick) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         period_ff <= TRIGGER_PERIOD_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
         sum_ff <= '0;
         bcd_ff <= '0;
         show_high_ff <= 1'b0;
         tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRIGGER_PERIOD: period_ff <= csr_wdata;
               CSR_FULL_SCALE:     full_scale_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         sum_ff <= sum_in;
         if (st.wr) begin
            bcd_ff <= st.bcd;
         end
         if (pop_tick) begin
            show_high_ff <= !show_high_ff;
            tick_ff <= tick_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_tick_waits_conversion: assert property (@(posedge clock) disable iff (reset)
      pop_tick |-> !st.busy)
      else $error("tick taken while conversion in flight");

   a_digit_alternates: assert property (@(posedge clock) disable iff (reset)
      pop_tick |=> show_high_ff != $past(show_high_ff))
      else $error("digit select did not alternate");

   a_one_digit_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_data_ff.low_digit_on, rsp_data_ff.high_digit_on}))
      else $error("digit enables not exclusive");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop_tick)
      else $error("pending response overwritten");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for adc_average_voltmeter_display_unit: queued sample and tick
// words, bursty sender, stalling receiver, in-bench display predictor. Depends on avm_pkg.
module tb_top;
   import avm_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RUN_PHASES = 8;
   localparam int PHASE_WORDS = 172;
   localparam int MAX_PRINTS = 40;
   localparam logic [111:0] SEG_BITS = {
      7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
      7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_STRIDE,
      RX_SPARSE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type word_q[$];
   rsp_type display_q[$];
   int errors = 0;
   int cycles = 0;

   logic [9:0] m_period = TRIGGER_PERIOD_RESET;
   logic [6:0] m_scale = FULL_SCALE_RESET;
   int m_sum = 0;
   int m_count = 0;
   logic [7:0] m_bcd = '0;
   logic m_high = 1'b0;
   logic [9:0] m_tick = '0;

   int burst_left = 0;
   int gap_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_left = 0;
   int rx_phase = 0;

   adc_average_voltmeter_display_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < MAX_PRINTS)
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // advance the voltmeter state by one accepted word
   task automatic predict_display(input req_type w);
      int avg;
      int scaled;
      int nxt;
      rsp_type r;
      logic [3:0] digit;
      if (w.op == KIND_SAMPLE) begin
         m_sum += w.sample;
         m_count++;
         if (m_count >= 8) begin
            avg = m_sum / 8;
            scaled = (avg * m_scale + 511) / 1023;
            if (scaled > 99)
               scaled = 99;
            m_bcd = {4'(scaled / 10), 4'(scaled % 10)};
            m_sum = 0;
            m_count = 0;
         end
      end else begin
         digit = m_high ? m_bcd[7:4] : m_bcd[3:0];
         r.segments = SEG_BITS[digit*7 +: 7];
         r.low_digit_on = !m_high;
         r.high_digit_on = m_high;
         r.start_conversion = (m_tick == 10'd0);
         r.shown_value = m_bcd;
         nxt = m_tick + 1;
         if (nxt >= m_period)
            nxt = 0;
         m_tick = nxt[9:0];
         m_high = !m_high;
         display_q.push_back(r);
      end
   endtask

   task automatic check_display(input rsp_type got);
      rsp_type want;
      if (display_q.size() == 0) begin
         report_mismatch("unexpected word", got, 0);
      end else begin
         want = display_q.pop_front();
         if (got.segments !== want.segments)
            report_mismatch("segments", got.segments, want.segments);
         if (got.low_digit_on !== want.low_digit_on)
            report_mismatch("low_digit_on", got.low_digit_on, want.low_digit_on);
         if (got.high_digit_on !== want.high_digit_on)
            report_mismatch("high_digit_on", got.high_digit_on, want.high_digit_on);
         if (got.start_conversion !== want.start_conversion)
            report_mismatch("start_conversion", got.start_conversion, want.start_conversion);
         if (got.shown_value !== want.shown_value)
            report_mismatch("shown_value", got.shown_value, want.shown_value);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TRIGGER_PERIOD: m_period = data[9:0];
         CSR_FULL_SCALE: m_scale = data[6:0];
         default: ;
      endcase
   endtask

   task automatic push_word(input kind_type kind, input logic [9:0] value);
      req_type w;
      w.op = kind;
      w.sample = value;
      word_q.push_back(w);
   endtask

   task automatic drain;
      do
         @(posedge clock);
      while (word_q.size() != 0 || req_valid || display_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic fill_random(input int count);
      int level;
      int value;
      int taken;
      level = $urandom_range(0, 1023);
      taken = 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 45) begin
            push_word(KIND_TICK, 10'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: value = $urandom_range(0, 1023);
               1: value = $urandom_range(0, 1) ? 1023 : 0;
               default: value = level + $urandom_range(0, 16) - 8;
            endcase
            if (value < 0)
               value = 0;
            if (value > 1023)
               value = 1023;
            push_word(KIND_SAMPLE, 10'(value));
            taken++;
            if (taken % 8 == 0)
               level = $urandom_range(0, 1023);
         end
      end
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready)
            predict_display(req_data);
         if (req_valid && !req_ready) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (word_q.size() > 0) begin
            req_data <= word_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 15) == 0)
                  gap_left = $urandom_range(20, 40);
               else if ($urandom_range(0, 2) == 0)
                  gap_left = 0;
               else
                  gap_left = $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_display(rsp_data);
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         rx_phase++;
         case (rx_mode)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            RX_STRIDE: rsp_ready <= (rx_phase % 3 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero display, start pulse, full-scale burst, alternating bits
      push_word(KIND_TICK, 10'h000);
      push_word(KIND_TICK, 10'h3FF);
      for (int i = 0; i < 8; i++)
         push_word(KIND_SAMPLE, (i % 2 == 0) ? 10'h3FF : 10'h3FF);
      push_word(KIND_TICK, 10'h2AA);
      push_word(KIND_TICK, 10'h155);
      drain();

      // saturated scale, period one, writes to unused indexes dropped
      csr_write(CSR_FULL_SCALE, 10'd127);
      csr_write(CSR_TRIGGER_PERIOD, 10'd1);
      csr_write(2'd2, 10'h3FF);
      csr_write(2'd3, 10'h000);
      for (int i = 0; i < 8; i++)
         push_word(KIND_SAMPLE, (i < 4) ? 10'h2AA : 10'h155);
      push_word(KIND_TICK, 10'h000);
      push_word(KIND_TICK, 10'h000);
      push_word(KIND_TICK, 10'h000);
      drain();

      for (int p = 0; p < RUN_PHASES; p++) begin
         case (p)
            0: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'd1023);
               csr_write(CSR_FULL_SCALE, 10'd99);
            end
            1: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'd5);
               csr_write(CSR_FULL_SCALE, 10'd0);
            end
            2: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'd0);
               csr_write(CSR_FULL_SCALE, {3'b101, 7'd60});
            end
            3: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'd2);
               csr_write(CSR_FULL_SCALE, 10'd127);
            end
            4: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'd1);
               csr_write(CSR_FULL_SCALE, 10'd1);
            end
            default: begin
               csr_write(CSR_TRIGGER_PERIOD, 10'($urandom_range(0, 40)));
               csr_write(CSR_FULL_SCALE, 10'($urandom_range(0, 127)));
               csr_write(2'd3, 10'($urandom));
            end
         endcase
         fill_random(PHASE_WORDS);
         drain();
      end

      repeat (20) @(posedge clock);
      while (display_q.size() != 0) begin
         report_mismatch("missing word", 0, display_q.pop_front());
      end
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
